/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks of the joint controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/ctjc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Computed-torque controller package
// Widths, codes and reset values shared by the controller files.
// ----------------------------------------------------------------------------
package ctjc_pkg;

   localparam int DATA_W   = 32;   // Q16.16 data words
   localparam int JIDX_W   = 3;    // joint, row and column index fields
   localparam int GAIN_W   = 31;   // unsigned Q15.16 gains
   localparam int CSR_IDX_W = 2;
   localparam int ACC_W    = 48;   // row accumulator
   localparam int SUM_W    = 50;   // working sum, wide enough for every step
   localparam int MUL_W    = 33;   // multiplier operand width
   localparam int PROD_W   = 2 * MUL_W;
   localparam int FRAC_W   = 16;

   localparam int MAX_JOINTS_DEFAULT = 7;

   localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(65536);
   localparam logic [JIDX_W-1:0] JOINTS_RESET = JIDX_W'(7);

   localparam logic FUNC_JOINT   = 1'b0;
   localparam logic FUNC_INERTIA = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_POSITION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_VELOCITY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JOINTS_IN_USE = 2'd2;

endpackage

/* hdl/ctjc_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Controller channels
// Valid/ready channels for joint and inertia words in and torque words out.
// ----------------------------------------------------------------------------
interface ctjc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic        [ctjc_pkg::JIDX_W-1:0]   row_index;
   logic        [ctjc_pkg::JIDX_W-1:0]   col_index;
   logic signed [ctjc_pkg::DATA_W-1:0]   pos_target;
   logic signed [ctjc_pkg::DATA_W-1:0]   vel_target;
   logic signed [ctjc_pkg::DATA_W-1:0]   acc_target;
   logic signed [ctjc_pkg::DATA_W-1:0]   pos_measured;
   logic signed [ctjc_pkg::DATA_W-1:0]   vel_measured;
   logic signed [ctjc_pkg::DATA_W-1:0]   inertia_element;
   logic signed [ctjc_pkg::DATA_W-1:0]   bias_torque;

   modport source (
      output valid, func, row_index, col_index, pos_target, vel_target, acc_target,
             pos_measured, vel_measured, inertia_element, bias_torque,
      input  ready
   );
   modport sink (
      input  valid, func, row_index, col_index, pos_target, vel_target, acc_target,
             pos_measured, vel_measured, inertia_element, bias_torque,
      output ready
   );
endinterface

interface ctjc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [ctjc_pkg::JIDX_W-1:0]   torque_row;
   logic signed [ctjc_pkg::DATA_W-1:0]   torque;
   logic                                 clipped;

   modport source (
      output valid, torque_row, torque, clipped,
      input  ready
   );
   modport sink (
      input  valid, torque_row, torque, clipped,
      output ready
   );
endinterface

/* hdl/ctjc_mult.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33 x 33 multiplier with a registered product, time-shared by the
// gain products and the inertia products.
// ----------------------------------------------------------------------------
module ctjc_mult (
   input  logic                                clock,
   input  logic signed [ctjc_pkg::MUL_W-1:0]   op_a,
   input  logic signed [ctjc_pkg::MUL_W-1:0]   op_b,
   output logic signed [ctjc_pkg::PROD_W-1:0]  prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

/* hdl/ctjc_ref_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference acceleration store
// One entry per joint, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ctjc_ref_store #(
   parameter int DEPTH  = ctjc_pkg::MAX_JOINTS_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic        [ADDR_W-1:0]           wr_addr,
   input  logic signed [ctjc_pkg::DATA_W-1:0] wr_data,
   input  logic                               rd_en,
   input  logic        [ADDR_W-1:0]           rd_addr,
   output logic signed [ctjc_pkg::DATA_W-1:0] rd_data_ff
);

   logic signed [ctjc_pkg::DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

/* hdl/computed_torque_joint_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Computed-torque joint controller
// Stores v = ddq_des + Kd*(dq_des - dq) + Kp*(q_des - q) per joint and
// streams tau(i) = bias(i) + sum_j M(i,j)*v(j), all in Q16.16.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req_chan  in         joint word (func 0) or inertia element word (func 1)
//   rsp_chan  out        torque word at the last column of a row
//   csr_*     in         register writes: Kp, Kd, joints in use
//
// A joint word passes through accept, two products, and sum and store, and an
// inertia word through accept, product and accumulate, all paced by the one
// shared 33 x 33 multiplier and its product register. The block is not ready
// while a word is in work. A torque word waits in an output register; the
// next word is accepted meanwhile, and its last-column step holds until that
// register is free. Reset is synchronous and clears the gains to 1.0, the
// joint count to 7 and the row accumulator to zero.
//
module computed_torque_joint_control #(
   parameter int MAX_JOINTS = ctjc_pkg::MAX_JOINTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ctjc_req_if.sink                             req_chan,
   ctjc_rsp_if.source                           rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [ctjc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ctjc_pkg::GAIN_W-1:0]          csr_wdata
);

   `include "assert_macros.svh"

   localparam int ADDR_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int DW     = ctjc_pkg::DATA_W;
   localparam int SW     = ctjc_pkg::SUM_W;
   localparam int AW     = ctjc_pkg::ACC_W;
   localparam int MW     = ctjc_pkg::MUL_W;
   localparam int PW     = ctjc_pkg::PROD_W;
   localparam logic [4:0] MAXJ = 5'(MAX_JOINTS);

   localparam logic signed [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [AW-1:0] ACC_MAX  = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] ACC_MIN  = {1'b1, {(AW-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_D,
      ST_MUL_P,
      ST_ADD_P,
      ST_MUL_M,
      ST_ACC_M
   } state_type;

   state_type state_ff, state_in;

   logic [ctjc_pkg::GAIN_W-1:0] gain_pos_ff, gain_pos_in;
   logic [ctjc_pkg::GAIN_W-1:0] gain_vel_ff, gain_vel_in;
   logic [ctjc_pkg::JIDX_W-1:0] joints_ff, joints_in;

   logic signed [SW-1:0]  sum_ff, sum_in;
   logic signed [AW-1:0]  acc_ff, acc_in;
   logic signed [MW-1:0]  opa_ff, opa_in;
   logic signed [MW-1:0]  ope_ff, ope_in;
   logic [ctjc_pkg::JIDX_W-1:0] row_ff, row_in;
   logic                  last_ff, last_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ctjc_pkg::JIDX_W-1:0] rsp_row_ff, rsp_row_in;
   logic signed [DW-1:0]  rsp_torque_ff, rsp_torque_in;
   logic                  rsp_clipped_ff, rsp_clipped_in;

   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [PW-1:0]  prod_ff;
   logic signed [DW-1:0]  rd_data_ff;
   logic                  wr_en;
   logic signed [DW-1:0]  wr_data;

   logic [4:0]            n_eff, jn5, row5, col5;
   logic                  accept, in_range, out_free;
   logic signed [SW-1:0]  term, sum_new;
   logic                  fits32, fits48;
   logic signed [DW-1:0]  sat32;
   logic signed [AW-1:0]  sat48;

   // Effective joint count, clamped to one through the store depth.
   assign jn5   = 5'(joints_ff);
   assign n_eff = (joints_ff == '0) ? 5'd1 : ((jn5 > MAXJ) ? MAXJ : jn5);
   assign row5  = 5'(req_chan.row_index);
   assign col5  = 5'(req_chan.col_index);
   assign in_range = (row5 < n_eff) &&
                     ((req_chan.func == ctjc_pkg::FUNC_JOINT) || (col5 < n_eff));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Product floored to Q16.16, then the single shared adder.
   assign term    = $signed(prod_ff[PW-1:ctjc_pkg::FRAC_W]);
   assign sum_new = sum_ff + term;

   assign fits32 = (sum_new[SW-1:DW-1] == {(SW-DW+1){sum_new[SW-1]}});
   assign fits48 = (sum_new[SW-1:AW-1] == {(SW-AW+1){sum_new[SW-1]}});
   assign sat32  = fits32 ? sum_new[DW-1:0] : (sum_new[SW-1] ? DATA_MIN : DATA_MAX);
   assign sat48  = fits48 ? sum_new[AW-1:0] : (sum_new[SW-1] ? ACC_MIN : ACC_MAX);

   assign wr_en   = (state_ff == ST_ADD_P);
   assign wr_data = sat32;

   always_comb begin
      unique case (state_ff)
         ST_MUL_D: begin
            mul_a = opa_ff;
            mul_b = MW'(gain_vel_ff);
         end
         ST_MUL_P: begin
            mul_a = ope_ff;
            mul_b = MW'(gain_pos_ff);
         end
         // The operands stay on while the accumulate step waits, so the
         // product register keeps the inertia product.
         ST_MUL_M, ST_ACC_M: begin
            mul_a = opa_ff;
            mul_b = MW'(rd_data_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   ctjc_mult u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   ctjc_ref_store #(
      .DEPTH  (MAX_JOINTS),
      .ADDR_W (ADDR_W)
   ) u_ref_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (ADDR_W'(row_ff)),
      .wr_data    (wr_data),
      .rd_en      (accept),
      .rd_addr    (ADDR_W'(req_chan.col_index)),
      .rd_data_ff (rd_data_ff)
   );

   always_comb begin
      state_in       = state_ff;
      gain_pos_in    = gain_pos_ff;
      gain_vel_in    = gain_vel_ff;
      joints_in      = joints_ff;
      sum_in         = sum_ff;
      acc_in         = acc_ff;
      opa_in         = opa_ff;
      ope_in         = ope_ff;
      row_in         = row_ff;
      last_in        = last_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_torque_in  = rsp_torque_ff;
      rsp_clipped_in = rsp_clipped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      if (csr_wr_en) begin
         unique case (csr_index)
            ctjc_pkg::CSR_GAIN_POSITION: gain_pos_in = csr_wdata;
            ctjc_pkg::CSR_GAIN_VELOCITY: gain_vel_in = csr_wdata;
            ctjc_pkg::CSR_JOINTS_IN_USE: joints_in = csr_wdata[ctjc_pkg::JIDX_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Words with an index beyond the joints in use are dropped.
            if (accept && in_range) begin
               row_in  = req_chan.row_index;
               last_in = (col5 == n_eff - 5'd1);
               if (req_chan.func == ctjc_pkg::FUNC_JOINT) begin
                  ope_in   = MW'(req_chan.pos_target) - MW'(req_chan.pos_measured);
                  opa_in   = MW'(req_chan.vel_target) - MW'(req_chan.vel_measured);
                  sum_in   = SW'(req_chan.acc_target);
                  state_in = ST_MUL_D;
               end else begin
                  opa_in   = MW'(req_chan.inertia_element);
                  sum_in   = (req_chan.col_index == '0) ? SW'(req_chan.bias_torque)
                                                        : SW'(acc_ff);
                  state_in = ST_MUL_M;
               end
            end
         end
         ST_MUL_D: begin
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            sum_in   = sum_new;
            state_in = ST_ADD_P;
         end
         ST_ADD_P: begin
            state_in = ST_IDLE;
         end
         ST_MUL_M: begin
            state_in = ST_ACC_M;
         end
         ST_ACC_M: begin
            // A closing column waits until the torque register can take it.
            if (!last_ff || out_free) begin
               acc_in   = sat48;
               state_in = ST_IDLE;
               if (last_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_row_in     = row_ff;
                  rsp_torque_in  = sat32;
                  rsp_clipped_in = !fits32;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_pos_ff  <= ctjc_pkg::GAIN_RESET;
         gain_vel_ff  <= ctjc_pkg::GAIN_RESET;
         joints_ff    <= ctjc_pkg::JOINTS_RESET;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_pos_ff  <= gain_pos_in;
         gain_vel_ff  <= gain_vel_in;
         joints_ff    <= joints_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff         <= sum_in;
      opa_ff         <= opa_in;
      ope_ff         <= ope_in;
      row_ff         <= row_in;
      last_ff        <= last_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_torque_ff  <= rsp_torque_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.torque_row = rsp_row_ff;
   assign rsp_chan.torque     = rsp_torque_ff;
   assign rsp_chan.clipped    = rsp_clipped_ff;

   // A word within the joints in use keeps the block busy the following cycle.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept && in_range, !req_chan.ready)

   // A new torque word only ever comes out of the accumulate step.
   `ASSERT_IMPLY(a_rsp_from_acc, clock, reset,
                 rsp_chan.valid && !$past(rsp_chan.valid), $past(state_ff) == ST_ACC_M)

   // A saturated torque sits at one of the two limits.
   `ASSERT_IMPLY(a_clip_at_limit, clock, reset, rsp_chan.valid && rsp_chan.clipped,
                 (rsp_chan.torque == DATA_MAX) || (rsp_chan.torque == DATA_MIN))

endmodule
